// ===== hw/rtl/pfb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfb_pkg
// Types, constants and codes shared by the paged frame buffer draw engine.
// ----------------------------------------------------------------------------
package pfb_pkg;

   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 64;
   localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
   localparam int STORE_SIZE    = SCREEN_WIDTH * PAGE_COUNT;

   localparam int ADDR_W = $clog2(STORE_SIZE);
   localparam int COL_W  = $clog2(SCREEN_WIDTH + 1);
   localparam int ROW_W  = $clog2(SCREEN_HEIGHT + 1);
   localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int CRD_W  = 20;

   typedef logic signed [CRD_W-1:0] coord_type;

   typedef enum logic [1:0] {
      CMD_PIXEL = 2'd0,
      CMD_VLINE = 2'd1,
      CMD_RECT  = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      COLOR_BLACK   = 2'd0,
      COLOR_WHITE   = 2'd1,
      COLOR_INVERSE = 2'd2,
      COLOR_KEEP    = 2'd3
   } color_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_CLIP,
      ST_RD,
      ST_WR,
      ST_RDB,
      ST_RDC,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [15:0] x_pos;
      logic signed [15:0] y_pos;
      logic signed [15:0] width_span;
      logic signed [15:0] height_span;
      logic [1:0]         color;
      logic [9:0]         read_address;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       done_res;
   } rsp_type;

endpackage

// ===== hw/rtl/page_framebuffer_line_rect_draw.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_framebuffer_line_rect_draw
// Monochrome paged frame store with pixel, line, rectangle and read commands.
// ----------------------------------------------------------------------------
// After reset the store is cleared one byte per cycle (STORE_SIZE = 1024
// bytes) and req_stall stays high meanwhile; csr writes are taken anytime.
// Every draw command is mapped to a clipped screen rectangle, then a single
// read-modify-write path walks it column by column and page by page, reading
// and then writing each touched store byte, between setup/clip and finish.
// Reads pass RDB, RDC, FIN. One command is in work at a time; the response
// register lets the next command start while a response beat still waits.
module page_framebuffer_line_rect_draw (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pfb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pfb_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_wr_data
);
   import pfb_pkg::*;

   localparam coord_type SW = coord_type'(SCREEN_WIDTH);
   localparam coord_type SH = coord_type'(SCREEN_HEIGHT);
   localparam coord_type ONE = coord_type'(1);
   localparam coord_type ZERO = coord_type'(0);

   state_type state_ff, state_in;
   logic [1:0] rot_ff, rot_in;
   req_type item_ff, item_in;
   coord_type cl_ff, ch_ff, rl_ff, rh_ff;
   coord_type cl_in, ch_in, rl_in, rh_in;
   logic [COL_W-1:0] c1_ff, c1_in, col_ff, col_in;
   logic [ROW_W-1:0] r0_ff, r0_in, r1_ff, r1_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [7:0] data_ff, data_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [7:0] mem [STORE_SIZE];
   logic [7:0] rdata_ff;
   logic [ADDR_W-1:0] rd_addr, wr_addr, cur_addr;
   logic mem_we;
   logic [7:0] wr_byte;

   coord_type a, n, hh, y, clo, chi, rlo, rhi;
   logic empty;
   logic [PAGE_W-1:0] pf, pl;
   logic [ROW_W-1:0] rlast;
   logic [7:0] m_lo, m_hi, mask;
   logic accept, load, col_end, page_end;

   assign accept = (state_ff == ST_IDLE) && req_valid;
   assign load = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);

   assign pf = PAGE_W'(r0_ff >> 3);
   assign rlast = r1_ff - ROW_W'(1);
   assign pl = PAGE_W'(rlast >> 3);
   assign page_end = (page_ff == pl);
   assign col_end = (col_ff == c1_ff - COL_W'(1));
   assign cur_addr = ADDR_W'(page_ff) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col_ff);

   // raw bounds
   always_comb begin
      a = coord_type'(item_ff.x_pos);
      y = coord_type'(item_ff.y_pos);
      n = (item_ff.command == CMD_RECT) ? coord_type'(item_ff.width_span) : ONE;
      hh = (item_ff.command == CMD_PIXEL) ? ONE : coord_type'(item_ff.height_span);
      cl_in = a;
      ch_in = a + n;
      rl_in = y;
      rh_in = y + hh;
      if (item_ff.command != CMD_PIXEL) begin
         case (rot_ff)
            2'd1: begin
               cl_in = SW - y - hh;
               ch_in = SW - y;
               rl_in = a;
               rh_in = a + n;
            end
            2'd2: begin
               cl_in = SW - a - n;
               ch_in = SW - a;
               rl_in = SH - y - hh;
               rh_in = SH - y;
            end
            2'd3: begin
               cl_in = y;
               ch_in = y + hh;
               rl_in = SH - a - n;
               rh_in = SH - a;
            end
            default: ;
         endcase
      end
   end

   // clipped bounds
   always_comb begin
      clo = (cl_ff < ZERO) ? ZERO : cl_ff;
      chi = (ch_ff > SW) ? SW : ch_ff;
      rlo = (rl_ff < ZERO) ? ZERO : rl_ff;
      rhi = (rh_ff > SH) ? SH : rh_ff;
      empty = (clo >= chi) || (rlo >= rhi);
   end

   always_comb begin
      m_lo = (page_ff == pf) ? (8'hFF << r0_ff[2:0]) : 8'hFF;
      m_hi = (page_ff == pl) ? (8'hFF >> (3'd7 - rlast[2:0])) : 8'hFF;
      mask = m_lo & m_hi;
      case (color_type'(item_ff.color))
         COLOR_BLACK:   wr_byte = rdata_ff & ~mask;
         COLOR_WHITE:   wr_byte = rdata_ff | mask;
         COLOR_INVERSE: wr_byte = rdata_ff ^ mask;
         default:       wr_byte = rdata_ff;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff == ADDR_W'(STORE_SIZE - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_data.command == CMD_READ) ? ST_RDB : ST_SETUP;
            end
         end
         ST_SETUP: state_in = ST_CLIP;
         ST_CLIP: begin
            if (empty || item_ff.color == COLOR_KEEP) state_in = ST_FIN;
            else state_in = ST_RD;
         end
         ST_RD: state_in = ST_WR;
         ST_WR: state_in = (page_end && col_end) ? ST_FIN : ST_RD;
         ST_RDB: state_in = ST_RDC;
         ST_RDC: state_in = ST_FIN;
         ST_FIN: if (load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      rot_in = csr_wr_en ? csr_wr_data : rot_ff;
      item_in = accept ? req_data : item_ff;
      clr_in = clr_ff;
      col_in = col_ff;
      page_in = page_ff;
      c1_in = c1_ff;
      r0_in = r0_ff;
      r1_in = r1_ff;
      data_in = data_ff;
      rsp_in = rsp_ff;
      rd_addr = cur_addr;
      wr_addr = cur_addr;
      mem_we = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            wr_addr = clr_ff;
            mem_we = 1'b1;
            clr_in = clr_ff + ADDR_W'(1);
         end
         ST_IDLE: data_in = 8'h00;
         ST_CLIP: begin
            col_in = COL_W'(clo);
            c1_in = COL_W'(chi);
            r0_in = ROW_W'(rlo);
            r1_in = ROW_W'(rhi);
            page_in = PAGE_W'(rlo >>> 3);
         end
         ST_WR: begin
            mem_we = 1'b1;
            if (page_end) begin
               page_in = pf;
               col_in = col_ff + COL_W'(1);
            end else begin
               page_in = page_ff + PAGE_W'(1);
            end
         end
         ST_RDB: rd_addr = ADDR_W'(item_ff.read_address);
         ST_RDC: begin
            if (int'(item_ff.read_address) < STORE_SIZE) data_in = rdata_ff;
            else data_in = 8'h00;
         end
         ST_FIN: begin
            if (load) begin
               rsp_in.read_data = data_ff;
               rsp_in.done_res = 1'b1;
            end
         end
         default: ;
      endcase
      if (load) rsp_valid_in = 1'b1;
      else rsp_valid_in = rsp_valid_ff && rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rot_ff <= 2'd0;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rot_ff <= rot_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      cl_ff <= cl_in;
      ch_ff <= ch_in;
      rl_ff <= rl_in;
      rh_ff <= rh_in;
      col_ff <= col_in;
      page_ff <= page_in;
      c1_ff <= c1_in;
      r0_ff <= r0_in;
      r1_ff <= r1_in;
      data_ff <= data_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= (state_ff == ST_CLEAR) ? 8'h00 : wr_byte;
      rdata_ff <= mem[rd_addr];
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_we_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_WR || state_ff == ST_CLEAR))
      else $error("store write outside a write state");

   a_walk_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR) |-> (col_ff < c1_ff && page_ff <= pl && page_ff >= pf))
      else $error("walk left the clipped rectangle");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("finished command produced no response");

endmodule
